@@ hdl/sliding_window_interquartile_mean_macros.svh @@
// Assertion macros for the filter RTL.
`ifndef SLIDING_WINDOW_INTERQUARTILE_MEAN_MACROS_SVH
`define SLIDING_WINDOW_INTERQUARTILE_MEAN_MACROS_SVH
`ifndef ASSERT_OFF
`define SWIM_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("swim assertion failed");
`define SWIM_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("swim assertion failed");
`else
`define SWIM_ASSERT_IMP(name, pre, post)
`define SWIM_ASSERT_NEXT(name, pre, post)
`endif
`endif

@@ hdl/swim_pkg.sv @@
// Shared types for the sliding-window interquartile mean filter.
package swim_pkg;

  // Per-cell status seen by the neighbor and by the sum logic.
  typedef struct packed {
    logic shl;  // cell takes its right neighbor's entry during eviction
    logic ge;   // compacted entry is > the new sample (always set in the last cell)
  } swim_flags_t;

endpackage

@@ hdl/sliding_window_interquartile_mean.sv @@
// Top level: sliding-window interquartile mean filter built as a chain of cells.
// Flow: an accepted sample moves the block to HOLD; the result is registered from HOLD
//   once the output register is free, and no new sample is taken until then. The cell
//   chain evicts and inserts in the accept cycle; the middle-half running sum is finished in HOLD.
// Reset (rst, synchronous): window cleared to zero, ages 0..WINDOW-1, sum zero,
//   no result pending.
`include "sliding_window_interquartile_mean_macros.svh"
module sliding_window_interquartile_mean #(
  parameter int WINDOW      = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          trimmed_mean_valid,
  input  logic                          trimmed_mean_ready,
  output logic signed [SAMPLE_BITS-1:0] trimmed_mean
);

  localparam int AGE_W = $clog2(WINDOW);
  localparam int Q     = WINDOW / 4;
  localparam int WQ    = WINDOW - Q;
  localparam int SUM_W = SAMPLE_BITS + AGE_W;
  localparam int D_W   = SAMPLE_BITS + 1;
  localparam int SH    = AGE_W - 1;

  typedef enum logic {IDLE, HOLD} state_t;
  state_t state;

  logic signed [SAMPLE_BITS-1:0] val   [WINDOW];
  logic        [AGE_W-1:0]       age   [WINDOW];
  logic signed [SAMPLE_BITS-1:0] c_val [WINDOW];
  logic        [AGE_W-1:0]       c_age [WINDOW];
  swim_pkg::swim_flags_t         flags [WINDOW];
  logic        [WINDOW-1:0]      evict;
  logic signed [SAMPLE_BITS-1:0] v_old;
  logic        [AGE_W-1:0]       ev_idx;

  logic                 accept;
  logic                 out_free;
  logic signed [D_W-1:0]   ev_delta, ins_delta_next, ins_delta;
  logic signed [SUM_W-1:0] sum, sum_mid, sum_total;

  assign sample_ready = (state == IDLE);
  assign accept       = sample_valid && sample_ready;
  assign out_free     = !trimmed_mean_valid || trimmed_mean_ready;

  // The chain: each cell sees its right neighbor's stored entry and its left
  // neighbor's compacted entry; the end cells get tied-off links.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] rv, lv;
    logic        [AGE_W-1:0]       ra, la;
    swim_pkg::swim_flags_t         lf;
    if (i == WINDOW - 1) begin : g_r_end
      assign rv = '0;
      assign ra = '0;
    end else begin : g_r
      assign rv = val[i+1];
      assign ra = age[i+1];
    end
    if (i == 0) begin : g_l_end
      assign lv = '0;
      assign la = '0;
      assign lf = '0;
    end else begin : g_l
      assign lv = c_val[i-1];
      assign la = c_age[i-1];
      assign lf = flags[i-1];
    end
    swim_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .AGE_W      (AGE_W),
      .INDEX      (i),
      .LAST       (i == WINDOW - 1)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (accept),
      .x         (sample),
      .ev_idx    (ev_idx),
      .right_val (rv),
      .right_age (ra),
      .left_c_val(lv),
      .left_c_age(la),
      .left_flags(lf),
      .val       (val[i]),
      .age       (age[i]),
      .evict     (evict[i]),
      .c_val     (c_val[i]),
      .c_age     (c_age[i]),
      .flags     (flags[i])
    );
  end

  // Pick out the value and position of the single oldest cell.
  always_comb begin
    v_old  = '0;
    ev_idx = '0;
    for (int i = 0; i < WINDOW; i++) begin
      v_old  = v_old | (evict[i] ? val[i] : '0);
      ev_idx = ev_idx | (evict[i] ? AGE_W'(i) : '0);
    end
  end

  // Running middle-half sum, updated by what crosses the quartile borders.
  always_comb begin
    // eviction: below the band shifts one entry in from the top, inside the
    // band drops the evicted value and takes in val[WQ], above leaves it alone
    if (flags[Q-1].shl) begin
      ev_delta = D_W'(val[WQ]) - D_W'(val[Q]);
    end else if (flags[WQ-1].shl) begin
      ev_delta = D_W'(val[WQ]) - D_W'(v_old);
    end else begin
      ev_delta = '0;
    end
    // insertion into the compacted window
    if (flags[Q-1].ge) begin
      ins_delta_next = D_W'(c_val[Q-1]) - D_W'(c_val[WQ-1]);
    end else if (flags[WQ-1].ge) begin
      ins_delta_next = D_W'(sample) - D_W'(c_val[WQ-1]);
    end else begin
      ins_delta_next = '0;
    end
    sum_total = sum_mid + SUM_W'(ins_delta);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= IDLE;
      sum                <= '0;
      trimmed_mean_valid <= 1'b0;
    end else begin
      if (trimmed_mean_ready) begin
        trimmed_mean_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            sum_mid   <= sum + SUM_W'(ev_delta);
            ins_delta <= ins_delta_next;
            state     <= HOLD;
          end
        end
        HOLD: begin
          // hold until the output register can take the result
          if (out_free) begin
            sum                <= sum_total;
            trimmed_mean       <= SAMPLE_BITS'(sum_total >>> SH);
            trimmed_mean_valid <= 1'b1;
            state              <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // Ages stay a permutation, so exactly one cell is ever the oldest.
  `SWIM_ASSERT_IMP(a_one_oldest, 1'b1, $onehot(evict))
  `SWIM_ASSERT_NEXT(a_accept_holds, accept, state == HOLD && !sample_ready)
  `SWIM_ASSERT_NEXT(a_result_out, state == HOLD && out_free, trimmed_mean_valid && sample_ready)

endmodule

@@ hdl/swim_cell.sv @@
// One cell of the sorted window: evict, age and insert in a single step.
module swim_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int AGE_W       = 8,
  parameter int INDEX       = 0,
  parameter bit LAST        = 1'b0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic        [AGE_W-1:0]       ev_idx,
  input  logic signed [SAMPLE_BITS-1:0] right_val,
  input  logic        [AGE_W-1:0]       right_age,
  input  logic signed [SAMPLE_BITS-1:0] left_c_val,
  input  logic        [AGE_W-1:0]       left_c_age,
  input  swim_pkg::swim_flags_t         left_flags,
  output logic signed [SAMPLE_BITS-1:0] val,
  output logic        [AGE_W-1:0]       age,
  output logic                          evict,
  output logic signed [SAMPLE_BITS-1:0] c_val,
  output logic        [AGE_W-1:0]       c_age,
  output swim_pkg::swim_flags_t         flags
);

  always_comb begin
    evict     = (age == {AGE_W{1'b1}});
    // every cell at or right of the evicted one closes the gap
    flags.shl = (AGE_W'(INDEX) >= ev_idx);
    c_val     = flags.shl ? right_val : val;
    c_age     = (flags.shl ? right_age : age) + AGE_W'(1);
    // the new sample goes after every entry equal to it
    flags.ge  = LAST ? 1'b1 : (c_val > x);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
      age <= AGE_W'(INDEX);
    end else if (en) begin
      if (!flags.ge) begin
        val <= c_val;
        age <= c_age;
      end else if (!left_flags.ge) begin
        val <= x;
        age <= '0;
      end else begin
        val <= left_c_val;
        age <= left_c_age;
      end
    end
  end

endmodule

@@ test/swim_checker.sv @@
// Checker for the interquartile mean filter: predicts each result and compares it.
`timescale 1ns / 1ps
module swim_checker #(
  parameter int WINDOW      = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          sample_valid,
  input  logic                          sample_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          trimmed_mean_valid,
  input  logic                          trimmed_mean_ready,
  input  logic signed [SAMPLE_BITS-1:0] trimmed_mean,
  output int                            fail_count,
  output int                            pending_means
);
  localparam int QUARTER = WINDOW / 4;
  localparam int SHIFT   = $clog2(WINDOW / 2);

  logic signed [SAMPLE_BITS-1:0] window_vals [WINDOW];
  int                            window_ages [WINDOW];
  logic signed [SAMPLE_BITS-1:0] mean_queue [$];

  assign pending_means = mean_queue.size();

  // Evict the oldest cell, age the rest, insert the new sample after equals.
  function automatic logic signed [SAMPLE_BITS-1:0] slide_window(
      logic signed [SAMPLE_BITS-1:0] x);
    int oldest;
    int pos;
    longint sum;
    oldest = 0;
    for (int i = 0; i < WINDOW; i++)
      if (window_ages[i] == WINDOW - 1) begin
        oldest = i;
        break;
      end
    for (int i = oldest; i < WINDOW - 1; i++) begin
      window_vals[i] = window_vals[i + 1];
      window_ages[i] = window_ages[i + 1];
    end
    for (int i = 0; i < WINDOW - 1; i++) window_ages[i] = (window_ages[i] + 1) % WINDOW;
    pos = 0;
    while (pos < WINDOW - 1 && window_vals[pos] <= x) pos++;
    for (int i = WINDOW - 1; i > pos; i--) begin
      window_vals[i] = window_vals[i - 1];
      window_ages[i] = window_ages[i - 1];
    end
    window_vals[pos] = x;
    window_ages[pos] = 0;
    sum = 0;
    for (int i = QUARTER; i < WINDOW - QUARTER; i++) sum += window_vals[i];
    // arithmetic shift gives the floor
    return SAMPLE_BITS'(sum >>> SHIFT);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        window_vals[i] = '0;
        window_ages[i] = i;
      end
      mean_queue = {};
      fail_count <= 0;
    end else begin
      if (trimmed_mean_valid && trimmed_mean_ready) begin
        if (mean_queue.size() == 0) begin
          $error("trimmed_mean: unexpected result %0d", trimmed_mean);
          fail_count <= fail_count + 1;
        end else if (mean_queue[0] !== trimmed_mean) begin
          $error("trimmed_mean: expected %0d, actual %0d", mean_queue[0], trimmed_mean);
          fail_count <= fail_count + 1;
          void'(mean_queue.pop_front());
        end else begin
          void'(mean_queue.pop_front());
        end
      end
      if (sample_valid && sample_ready) mean_queue.push_back(slide_window(sample));
    end
  end
endmodule

@@ test/tb_sliding_window_interquartile_mean.sv @@
// Testbench top: drives samples with random gaps and stalls and reports the verdict.
`timescale 1ns / 1ps
module tb_sliding_window_interquartile_mean;
  localparam int WINDOW      = 256;
  localparam int SAMPLE_BITS = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic                          clk;
  logic                          rst;
  logic                          sample_valid;
  logic                          sample_ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          trimmed_mean_valid;
  logic                          trimmed_mean_ready;
  logic signed [SAMPLE_BITS-1:0] trimmed_mean;
  int                            fail_count;
  int                            pending_means;
  int                            cycle_count;
  int                            send_idle_pct;
  int                            recv_stall_pct;

  sliding_window_interquartile_mean #(
    .WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (.*);

  swim_checker #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Count cycles and end the run if the block hangs.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sliding_window_interquartile_mean: mismatch");
      $finish;
    end
  end

  // Receiver: stall at the current phase's rate.
  always @(posedge clk) begin
    if (rst) trimmed_mean_ready <= 1'b0;
    else trimmed_mean_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Hold the request until accepted, idling at random before raising valid.
  task automatic send_sample(logic signed [SAMPLE_BITS-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= value;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  // Mostly a drifting signal with noise; sometimes extremes or full-range values.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int base);
    int kind;
    kind = $urandom_range(9);
    if (kind == 0) return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
    if (kind < 4) return SAMPLE_BITS'($urandom);
    return SAMPLE_BITS'(base + int'($urandom_range(2000)) - 1000);
  endfunction

  initial begin
    int base;
    rst                = 1'b1;
    sample_valid       = 1'b0;
    sample             = '0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, zeros against the unfilled slots, repeated equals.
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    repeat (6) send_sample(16'sh7fff);
    repeat (6) send_sample(16'sh8000);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);
    repeat (3) send_sample(16'sd7);

    // Random phases: none, sender idle, receiver stall, both.
    base = 0;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 19 : 0;
      recv_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 19 : 0;
      for (int n = 0; n < 160; n++) begin
        if (n % 40 == 0) base = $urandom_range(60000) - 30000;
        send_sample(pick_sample(base));
      end
    end
    sample_valid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // Drain, then allow the block's latency.
    while (pending_means != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_means == 0) begin
      $display("sliding_window_interquartile_mean: match");
    end else begin
      $display("sliding_window_interquartile_mean: mismatch");
    end
    $finish;
  end
endmodule
